/* hw/rtl/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared command and status codes and the result word of the sorted page.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int FOUND_W = 32;
  localparam int HELD_W  = 9;
  localparam int FIELD_W = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_GE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [FOUND_W-1:0] found_value;
    logic [HELD_W-1:0]  entries_held;
  } spt_result_t;

endpackage

`default_nettype wire

/* hw/rtl/spt_store.sv */
// ----------------------------------------------------------------------------
// spt_store
// Key and value memories: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_store #(
  parameter int DEPTH      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_key_i,
  input  wire logic                     we_val_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [KEY_BITS-1:0]      wkey_i,
  input  wire logic [VALUE_BITS-1:0]    wval_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [KEY_BITS-1:0]      rkey_o,
  output logic      [VALUE_BITS-1:0]    rval_o
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_key_i) begin
      key_mem[waddr_i] <= wkey_i;
    end
    if (we_val_i) begin
      val_mem[waddr_i] <= wval_i;
    end
    rkey_o <= key_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/spt_ctrl.sv */
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer: lower-bound binary search through one shared key comparator,
// hit check, in-memory shift for inserts, in-place key update.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ctrl #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    key_signed_i,
  input  wire logic                    start_i,
  input  wire logic [spt_pkg::CMD_W-1:0] cmd_i,
  input  wire logic [KEY_BITS-1:0]     key_i,
  input  wire logic [VALUE_BITS-1:0]   val_i,
  input  wire logic [KEY_BITS-1:0]     nkey_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output spt_pkg::spt_result_t         res_o
);

  import spt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [KEY_BITS-1:0]   nkey_q, nkey_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         hi_q, hi_d;
  logic [CW-1:0]         mid_q, mid_d;
  logic [CW-1:0]         sh_q, sh_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         pend_addr_q, pend_addr_d;
  spt_result_t           res_q, res_d;

  logic                  we_key, we_val;
  logic [AW-1:0]         waddr, raddr;
  logic [KEY_BITS-1:0]   wkey, rkey;
  logic [VALUE_BITS-1:0] wval, rval;

  logic [KEY_BITS-1:0]   sign_flip;
  logic                  key_below;
  logic [CW-1:0]         mid_c, sh_m1;
  logic                  in_range, hit;

  spt_store #(
    .DEPTH      (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .we_key_i (we_key),
    .we_val_i (we_val),
    .waddr_i  (waddr),
    .wkey_i   (wkey),
    .wval_i   (wval),
    .raddr_i  (raddr),
    .rkey_o   (rkey),
    .rval_o   (rval)
  );

  assign sign_flip = {key_signed_i, {(KEY_BITS-1){1'b0}}};
  assign key_below = (rkey ^ sign_flip) < (key_q ^ sign_flip);
  assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
  assign sh_m1     = sh_q - CW'(1);
  assign in_range  = lo_q < count_q;
  assign hit       = in_range && (rkey == key_q);

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    nkey_d      = nkey_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    sh_d        = sh_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_d       = res_q;
    we_key      = 1'b0;
    we_val      = 1'b0;
    waddr       = lo_q[AW-1:0];
    wkey        = key_q;
    wval        = val_q;
    raddr       = lo_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          key_d   = key_i;
          val_d   = val_i;
          nkey_d  = nkey_i;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          raddr   = mid_c[AW-1:0];
          mid_d   = mid_c;
          state_d = S_CMP;
        end else begin
          state_d = S_HIT;
        end
      end
      S_CMP: begin
        if (key_below) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_HIT: begin
        res_d.status       = ST_NOT_FOUND;
        res_d.found_value  = '0;
        res_d.entries_held = HELD_W'(count_q);
        state_d            = S_DONE;
        case (cmd_q)
          CMD_INSERT: begin
            if (hit) begin
              res_d.status = ST_DUPLICATE;
            end else if (count_q == CW'(CAPACITY)) begin
              res_d.status = ST_FULL;
            end else begin
              sh_d    = count_q;
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          CMD_LOOKUP: begin
            if (hit) begin
              res_d.status      = ST_OK;
              res_d.found_value = FOUND_W'(rval);
            end
          end
          CMD_LOOKUP_GE: begin
            if (in_range) begin
              res_d.status      = ST_OK;
              res_d.found_value = FOUND_W'(rval);
            end
          end
          default: begin
            if (hit) begin
              we_key       = 1'b1;
              wkey         = nkey_q;
              res_d.status = ST_OK;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (pend_q) begin
          we_key = 1'b1;
          we_val = 1'b1;
          waddr  = pend_addr_q;
          wkey   = rkey;
          wval   = rval;
        end
        if (sh_q > lo_q) begin
          raddr       = sh_m1[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = sh_q[AW-1:0];
          sh_d        = sh_m1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INS;
        end
      end
      S_INS: begin
        we_key             = 1'b1;
        we_val             = 1'b1;
        count_d            = count_q + CW'(1);
        res_d.status       = ST_OK;
        res_d.entries_held = HELD_W'(count_q + CW'(1));
        state_d            = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    val_q       <= val_d;
    nkey_q      <= nkey_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    sh_q        <= sh_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_page_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_page_table_unit
// Sorted key/value page of one B+ tree node with insert, lookup and update.
// ----------------------------------------------------------------------------
// One word is handled at a time. Every command runs a lower-bound binary search
// over the held entries, each probe reading through the registered read port
// of the key memory, then checks the hit. A new key is then inserted by moving
// the entries above the insertion point up one at a time before the new entry
// is written; the shift is bound by the one read and one write port of the
// memory. The result sits in an output register, so the next word may enter
// while a result waits to be taken.
// Memories start undefined; only entries below the fill count are ever used.
`default_nettype none

module sorted_page_table_unit #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,      // key_signed
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,    // search_key, entry_value, replacement_key
  input  wire logic [1:0]  s_axis_tuser,    // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,    // found_value, entries_held, zero pad
  output logic [1:0]       m_axis_tuser     // status
);

  import spt_pkg::*;

  logic        key_signed_q;
  logic        idle;
  logic        res_valid, res_ready;
  spt_result_t res;
  logic        m_valid_q;
  spt_result_t m_res_q;

  spt_ctrl #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_signed_i (key_signed_q),
    .start_i      (s_axis_tvalid && s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .key_i        (KEY_BITS'(s_axis_tdata[FIELD_W-1:0])),
    .val_i        (VALUE_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W])),
    .nkey_i       (KEY_BITS'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W])),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = idle;
  assign res_ready     = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_signed_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_signed_q <= cfg_data_i;
      end
      if (res_valid && res_ready) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {7'd0, m_res_q.entries_held, m_res_q.found_value};

endmodule

`default_nettype wire

/* hw/rtl/spt_checker.sv */
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks of the sorted page, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_checker #(
  parameter int CAPACITY = 256
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  import spt_pkg::*;

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("failed command returned a value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (m_axis_tdata[40:32] == 9'(CAPACITY)))
    else $error("page full reported below capacity");

endmodule

bind sorted_page_table_unit spt_checker #(.CAPACITY(CAPACITY)) u_spt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
